@@ sv/fixed_block_pool_allocator_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the fixed block pool allocator
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define FBPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pool allocator check failed");

// next-cycle implication
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pool allocator check failed");

`endif

@@ sv/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg
// Widths, codes and transfer types shared by the pool allocator modules.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int ADDR_BITS      = 32;
    localparam int AW1            = ADDR_BITS + 1;
    localparam int REGION_W       = 32;
    localparam int SIZE_W         = 13;
    localparam int ALIGN_W        = 4;
    localparam int REQ_W          = 2;
    localparam int STATUS_W       = 3;
    localparam int OUT_CNT_W      = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 13;
    localparam int STRIDE_W       = 2 ** ALIGN_W;
    localparam int QUEUE_DEPTH    = 2;
    localparam int MAX_BLOCKS_DEF = 1024;
    localparam int NODE_BYTES_DEF = 8;

    localparam logic [SIZE_W-1:0]  BLOCK_BYTES_RST = 13'd64;
    localparam logic [ALIGN_W-1:0] BLOCK_ALIGN_RST = 4'd3;

    localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REGION = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_BIG  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_OVER_ALN = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ALIGN = 2'd1;

    typedef struct packed {
        logic [REQ_W-1:0]    kind;
        logic [STATUS_W-1:0] status;
        logic [AW1-1:0]      base;
        logic [AW1-1:0]      lim;
        logic [SIZE_W-1:0]   chunk;
        logic [STRIDE_W-1:0] stride;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] granted_address;
        logic [STATUS_W-1:0]  status;
        logic [OUT_CNT_W-1:0] blocks_added;
        logic [OUT_CNT_W-1:0] free_blocks;
    } result_t;

endpackage

@@ sv/fbpa_fifo.sv @@
// ----------------------------------------------------------------------------
// fbpa_fifo
// Small flop-based queue used for the allocator's command and result queues.
// ----------------------------------------------------------------------------
module fbpa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = fbpa_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    import fbpa_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ sv/fbpa_front.sv @@
// ----------------------------------------------------------------------------
// fbpa_front
// Holds the configuration registers and classifies each request: size and
// alignment checks, region start, end and stride.
// ----------------------------------------------------------------------------
module fbpa_front #(
    parameter int NODE_BYTES = fbpa_pkg::NODE_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [fbpa_pkg::REQ_W-1:0]      req_type,
    input  logic [fbpa_pkg::ADDR_BITS-1:0]  address,
    input  logic [fbpa_pkg::REGION_W-1:0]   region_bytes,
    input  logic [fbpa_pkg::SIZE_W-1:0]     request_bytes,
    input  logic [fbpa_pkg::ALIGN_W-1:0]    request_align_log2,
    output fbpa_pkg::cmd_t                  cmd
);
    import fbpa_pkg::*;

    localparam logic [ALIGN_W-1:0] NODE_LOG2 = ALIGN_W'($clog2(NODE_BYTES));
    localparam logic [SIZE_W-1:0]  NODE_SIZE = SIZE_W'(NODE_BYTES);
    localparam logic [AW1-1:0]     ADDR_TOP  = AW1'(1) << ADDR_BITS;

    logic [SIZE_W-1:0]   block_bytes_reg;
    logic [ALIGN_W-1:0]  block_align_reg;
    logic [ALIGN_W-1:0]  eff_align;
    logic [ALIGN_W-1:0]  free_align;
    logic [STRIDE_W-1:0] align_mask;
    logic [SIZE_W-1:0]   alloc_size;
    logic [SIZE_W-1:0]   chunk;
    logic [AW1-1:0]      region_end;
    logic                bad_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg <= BLOCK_BYTES_RST;
            block_align_reg <= BLOCK_ALIGN_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_BLOCK_BYTES)
            begin
                block_bytes_reg <= cfg_data[SIZE_W-1:0];
            end
            else if (cfg_index == CFG_BLOCK_ALIGN)
            begin
                block_align_reg <= cfg_data[ALIGN_W-1:0];
            end
        end
    end

    always_comb
    begin
        eff_align  = (block_align_reg > NODE_LOG2) ? block_align_reg : NODE_LOG2;
        free_align = (request_align_log2 > NODE_LOG2) ? request_align_log2 : NODE_LOG2;
        align_mask = (STRIDE_W'(1) << eff_align) - STRIDE_W'(1);
        alloc_size = (request_bytes < NODE_SIZE) ? NODE_SIZE : request_bytes;
        chunk      = (block_bytes_reg == '0) ? SIZE_W'(1) : block_bytes_reg;
        region_end = AW1'(address) + AW1'(region_bytes);
        bad_free   = (request_bytes > block_bytes_reg) || (free_align != eff_align);

        cmd.kind   = req_type;
        cmd.chunk  = chunk;
        cmd.stride = (STRIDE_W'(chunk) + align_mask) & ~align_mask;
        cmd.lim    = (region_end > ADDR_TOP) ? ADDR_TOP : region_end;
        cmd.base   = AW1'(address);
        cmd.status = STATUS_OK;

        unique case (req_type)
            REQ_ALLOC:
            begin
                if (alloc_size > block_bytes_reg)
                begin
                    cmd.status = STATUS_TOO_BIG;
                end
                else if (request_align_log2 > eff_align)
                begin
                    cmd.status = STATUS_OVER_ALN;
                end
            end
            REQ_FREE:
            begin
                cmd.status = bad_free ? STATUS_BAD_FREE : STATUS_OK;
            end
            REQ_REGION:
            begin
                cmd.base = (AW1'(address) + AW1'(align_mask)) & ~AW1'(align_mask);
            end
            default:
            begin
                cmd.status = STATUS_OK;
            end
        endcase
    end

endmodule

@@ sv/fbpa_back.sv @@
// ----------------------------------------------------------------------------
// fbpa_back
// Owns the free-list stack RAM and its count; pops, pushes and carves
// regions one block per cycle, then issues one result per request.
// ----------------------------------------------------------------------------
module fbpa_back #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  fbpa_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    input  logic              res_ready,
    output logic              res_valid,
    output fbpa_pkg::result_t res
);
    import fbpa_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_GRANT = 2'd1;
    localparam logic [1:0] ST_CARVE = 2'd2;

    logic [ADDR_BITS-1:0] stack_mem [MAX_BLOCKS];

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     top_reg, top_next;
    logic [CNT_W-1:0]     added_reg, added_next;
    logic [AW1-1:0]       cur_reg, cur_next;
    logic [AW1-1:0]       lim_reg, lim_next;
    logic [SIZE_W-1:0]    chunk_reg, chunk_next;
    logic [STRIDE_W-1:0]  stride_reg, stride_next;
    logic [ADDR_BITS-1:0] rd_data_reg;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [ADDR_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_raddr;
    logic [CNT_W-1:0]     top_inc, top_dec;
    logic                 stack_full;
    logic                 block_fits;

    always_comb
    begin
        top_inc    = top_reg + CNT_W'(1);
        top_dec    = top_reg - CNT_W'(1);
        stack_full = (top_reg >= CNT_MAX);
        block_fits = ((AW1 + 1)'(cur_reg) + (AW1 + 1)'(chunk_reg)) <= (AW1 + 1)'(lim_reg);

        state_next  = state_reg;
        top_next    = top_reg;
        added_next  = added_reg;
        cur_next    = cur_reg;
        lim_next    = lim_reg;
        chunk_next  = chunk_reg;
        stride_next = stride_reg;
        mem_we      = 1'b0;
        mem_waddr   = top_reg[IDX_W-1:0];
        mem_wdata   = cur_reg[ADDR_BITS-1:0];
        mem_re      = 1'b0;
        mem_raddr   = top_dec[IDX_W-1:0];
        cmd_pop     = 1'b0;
        res_valid   = 1'b0;
        res.granted_address = '0;
        res.status          = STATUS_OK;
        res.blocks_added    = '0;
        res.free_blocks     = OUT_CNT_W'(top_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && res_ready)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        REQ_ALLOC:
                        begin
                            if (top_reg == '0)
                            begin
                                res_valid  = 1'b1;
                                res.status = STATUS_EMPTY;
                            end
                            else if (cmd.status != STATUS_OK)
                            begin
                                res_valid  = 1'b1;
                                res.status = cmd.status;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                top_next   = top_dec;
                                state_next = ST_GRANT;
                            end
                        end
                        REQ_FREE:
                        begin
                            res_valid = 1'b1;
                            if (stack_full)
                            begin
                                res.status = STATUS_FULL;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                mem_wdata       = cmd.base[ADDR_BITS-1:0];
                                top_next        = top_inc;
                                res.status      = cmd.status;
                                res.free_blocks = OUT_CNT_W'(top_inc);
                            end
                        end
                        REQ_REGION:
                        begin
                            cur_next    = cmd.base;
                            lim_next    = cmd.lim;
                            chunk_next  = cmd.chunk;
                            stride_next = cmd.stride;
                            added_next  = '0;
                            state_next  = ST_CARVE;
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_GRANT:
            begin
                res_valid           = 1'b1;
                res.granted_address = rd_data_reg;
                state_next          = ST_IDLE;
            end
            ST_CARVE:
            begin
                res.blocks_added = OUT_CNT_W'(added_reg);
                if (block_fits && stack_full)
                begin
                    res_valid  = 1'b1;
                    res.status = STATUS_FULL;
                    state_next = ST_IDLE;
                end
                else if (block_fits)
                begin
                    mem_we     = 1'b1;
                    top_next   = top_inc;
                    added_next = added_reg + CNT_W'(1);
                    cur_next   = cur_reg + AW1'(stride_reg);
                end
                else
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            top_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        added_reg  <= added_next;
        cur_reg    <= cur_next;
        lim_reg    <= lim_next;
        chunk_reg  <= chunk_next;
        stride_reg <= stride_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

endmodule

@@ sv/fixed_block_pool_allocator_top.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top
// LIFO free-list allocator for fixed-size blocks: allocate, free and
// region carving, with a command queue between classification and the
// stack engine and a result queue on the output.
//
// channel   direction  handshake            payload
// request   in         push / full          req_type, address, region_bytes,
//                                           request_bytes, request_align_log2
// result    out        empty / pop          granted_address, status,
//                                           blocks_added, free_blocks
// config    in         cfg_we               cfg_index, cfg_data
//
// Free, failed allocate and unknown requests: the stack engine issues the result as it pops the command.
// Successful allocate: the stack RAM read is registered, and the result is issued from ST_GRANT.
// Region: ST_CARVE makes one RAM write per carved block, then issues the result.
// Reset clears the stack count and queues; the stack RAM is not cleared.
// full rises when the two-entry command queue fills; results wait in a
// two-entry queue while pop is low.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_top #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int NODE_BYTES = fbpa_pkg::NODE_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [fbpa_pkg::REQ_W-1:0]      req_type,
    input  logic [fbpa_pkg::ADDR_BITS-1:0]  address,
    input  logic [fbpa_pkg::REGION_W-1:0]   region_bytes,
    input  logic [fbpa_pkg::SIZE_W-1:0]     request_bytes,
    input  logic [fbpa_pkg::ALIGN_W-1:0]    request_align_log2,
    output logic                            empty,
    input  logic                            pop,
    output logic [fbpa_pkg::ADDR_BITS-1:0]  granted_address,
    output logic [fbpa_pkg::STATUS_W-1:0]   status,
    output logic [fbpa_pkg::OUT_CNT_W-1:0]  blocks_added,
    output logic [fbpa_pkg::OUT_CNT_W-1:0]  free_blocks
);
    import fbpa_pkg::*;

    cmd_t    front_cmd;
    cmd_t    queued_cmd;
    logic    cmd_empty;
    logic    cmd_pop;
    logic    res_full;
    logic    res_valid;
    result_t back_res;
    result_t out_res;

    fbpa_front #(
        .NODE_BYTES (NODE_BYTES)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .req_type           (req_type),
        .address            (address),
        .region_bytes       (region_bytes),
        .request_bytes      (request_bytes),
        .request_align_log2 (request_align_log2),
        .cmd                (front_cmd)
    );

    fbpa_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_cmd),
        .rd_en   (cmd_pop),
        .rd_data (queued_cmd),
        .full    (full),
        .empty   (cmd_empty)
    );

    fbpa_back #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (queued_cmd),
        .cmd_pop   (cmd_pop),
        .res_ready (!res_full),
        .res_valid (res_valid),
        .res       (back_res)
    );

    fbpa_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (back_res),
        .rd_en   (pop),
        .rd_data (out_res),
        .full    (res_full),
        .empty   (empty)
    );

    assign granted_address = out_res.granted_address;
    assign status          = out_res.status;
    assign blocks_added    = out_res.blocks_added;
    assign free_blocks     = out_res.free_blocks;

endmodule

@@ sv/fbpa_checker.sv @@
// ----------------------------------------------------------------------------
// fbpa_checker
// Port-level checks on the result channel of the pool allocator.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_top_defines.svh"

module fbpa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           pop,
    input logic                           empty,
    input logic [fbpa_pkg::ADDR_BITS-1:0] granted_address,
    input logic [fbpa_pkg::STATUS_W-1:0]  status,
    input logic [fbpa_pkg::OUT_CNT_W-1:0] blocks_added,
    input logic [fbpa_pkg::OUT_CNT_W-1:0] free_blocks
);
    import fbpa_pkg::*;

    `FBPA_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop, !empty && $stable(granted_address) && $stable(status) && $stable(free_blocks))
    `FBPA_ASSERT_NOW(a_grant_only_ok, clk, rst_n, !empty && granted_address != '0, status == STATUS_OK && blocks_added == '0)
    `FBPA_ASSERT_NOW(a_empty_list, clk, rst_n, !empty && status == STATUS_EMPTY, free_blocks == '0 && granted_address == '0)
    `FBPA_ASSERT_NOW(a_added_on_list, clk, rst_n, !empty && blocks_added != '0, blocks_added <= free_blocks)

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (.*);
